FILE: rtl/core/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
// No dependencies.
package ffa_pkg;
    localparam int SLOTS_DEF   = 128;
    localparam int HEAP_DEF    = 64 * 1024 * 1024;
    localparam int HEADER_DEF  = 16;
    localparam int FW          = 27;   // field width
    localparam int EW          = 32;   // internal extent width, no wrap

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FREED   = 2'd2,
        ST_LOST    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FS_IDLE, FS_SCAN, FS_PUSH, FS_DONE
    } fsm_t;

    // token circulated along the cell chain
    typedef struct packed {
        logic          kind;    // 0 allocate, 1 free
        logic [EW-1:0] need;    // alloc size, or running free length
        logic [EW-1:0] off;     // free block start
        logic          hit;     // alloc found
        logic [EW-1:0] gstart;
        logic [EW-1:0] tlen;    // tail length to push
        logic [EW-1:0] toff;
    } token_t;
endpackage

FILE: rtl/core/ffa_cell.sv
// One extent slot of the allocator chain.
// Depends on ffa_pkg.
module ffa_cell import ffa_pkg::*; #(
    parameter logic [EW-1:0] INIT_LEN = '0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  logic          push_mode,
    input  logic          push_valid_in,
    input  logic [EW-1:0] push_len,
    input  logic [EW-1:0] push_off,
    input  logic [EW-1:0] len_in,
    input  logic [EW-1:0] off_in,
    output logic [EW-1:0] len_out,
    output logic [EW-1:0] off_out
);
    logic [EW-1:0] len_reg, off_reg;
    assign len_out = len_reg;
    assign off_out = off_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= INIT_LEN;
            off_reg <= '0;
        end else if (shift_en) begin
            len_reg <= len_in;
            off_reg <= off_in;
        end else if (push_mode && push_valid_in) begin
            len_reg <= push_len;
            off_reg <= push_off;
        end
    end
endmodule

FILE: rtl/core/ffa_head.sv
// Processing head: examines the slot leaving the chain, updates token.
// Depends on ffa_pkg.
module ffa_head import ffa_pkg::*; (
    input  logic          phase_push,
    input  token_t        tok,
    input  logic [EW-1:0] len_in,
    input  logic [EW-1:0] off_in,
    output token_t        tok_next,
    output logic [EW-1:0] len_back,
    output logic          push_take
);
    always_comb begin
        tok_next  = tok;
        len_back  = len_in;
        push_take = 1'b0;
        if (phase_push) begin
            if (len_in == '0 && tok.tlen != '0) begin
                len_back     = tok.tlen;
                push_take    = 1'b1;
                tok_next.tlen = '0;
            end
        end else if (!tok.kind) begin
            if (!tok.hit && len_in != '0 && len_in >= tok.need) begin
                tok_next.hit    = 1'b1;
                tok_next.gstart = off_in;
                tok_next.tlen   = len_in - tok.need;
                tok_next.toff   = off_in + tok.need;
                len_back        = '0;
            end
        end else if (len_in != '0 && off_in == tok.off + tok.need) begin
            tok_next.need = tok.need + len_in;
            len_back      = '0;
        end
    end
endmodule

FILE: rtl/core/first_fit_free_list_allocator.sv
// First-fit free-list allocator, top level.
// Depends on ffa_pkg, ffa_cell, ffa_head.
//
// Usage: one request transaction on s_axis (allocate or free), one result
// transaction on m_axis per request. The free table is a ring of SLOTS
// cells; while the ring rotates, the slot at position 0 passes through a
// head unit and back in every cycle, so one rotation is one ordered scan.
// Sequence: two rotations, then a hand-off state (FS_DONE). m_axis_tvalid
// and s_axis_tready rise together on leaving it. The first rotation finds
// a fit or merges, the second pushes the leftover extent, or the merged
// free block, into the first empty slot. One request is worked on at a
// time; s_axis_tready is high only while the ring is idle. The result
// sits in an output register until m_axis_tready; the next request is
// taken meanwhile and its result waits for the register to clear.
// Reset (synchronous): slot 0 holds the whole heap, all others empty.
// A stall on m_axis holds the result register, and a later request then
// waits in the hand-off state; the ring is never stalled mid-rotation.
module first_fit_free_list_allocator import ffa_pkg::*; #(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int HEAP_BYTES   = HEAP_DEF,
    parameter int HEADER_BYTES = HEADER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [26:0] request_bytes, [53:27] block_start, [80:54] block_bytes
    input  logic [87:0] s_axis_tdata,
    // tuser: [0] kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [1:0] status, [28:2] grant_start, [55:29] grant_bytes
    output logic [55:0] m_axis_tdata
);
    localparam int CW = $clog2(SLOTS + 1);

    fsm_t          state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    token_t        tok_reg, tok_next, head_tok;
    logic          mv_reg, mv_next;
    logic [55:0]   md_reg, md_next;

    logic [EW-1:0] len_c [SLOTS];
    logic [EW-1:0] off_c [SLOTS];
    logic [EW-1:0] len_back;
    logic          push_take, rot;

    // ring: cell i takes from cell i+1; last cell takes head output
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic [EW-1:0] li, oi;
        if (i == SLOTS - 1) begin : g_last
            assign li = len_back;
            assign oi = push_take ? tok_reg.toff : off_c[0];
        end else begin : g_mid
            assign li = len_c[i+1];
            assign oi = off_c[i+1];
        end
        ffa_cell #(.INIT_LEN(i == 0 ? EW'(HEAP_BYTES) : '0)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .shift_en(rot),
            .push_mode(1'b0), .push_valid_in(1'b0),
            .push_len('0), .push_off('0),
            .len_in(li), .off_in(oi),
            .len_out(len_c[i]), .off_out(off_c[i]));
    end

    ffa_head u_head (
        .phase_push(state_reg == FS_PUSH), .tok(tok_reg),
        .len_in(len_c[0]), .off_in(off_c[0]),
        .tok_next(head_tok), .len_back(len_back), .push_take(push_take));

    assign rot = (state_reg == FS_SCAN) || (state_reg == FS_PUSH);
    assign s_axis_tready = (state_reg == FS_IDLE);
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        tok_reg <= tok_next;
        md_reg  <= md_next;
    end

    always_comb begin
        logic       lost;
        logic [1:0] st;
        lost       = 1'b0;
        st         = ST_GRANTED;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tok_next   = tok_reg;
        mv_next    = mv_reg && !m_axis_tready;
        md_next    = md_reg;
        case (state_reg)
            FS_IDLE: begin
                if (s_axis_tvalid) begin
                    tok_next.kind = s_axis_tuser;
                    tok_next.hit  = 1'b0;
                    tok_next.tlen = '0;
                    tok_next.gstart = '0;
                    tok_next.off  = EW'(s_axis_tdata[53:27]);
                    tok_next.toff = EW'(s_axis_tdata[53:27]);
                    tok_next.need = s_axis_tuser ? EW'(s_axis_tdata[80:54])
                                  : EW'(s_axis_tdata[26:0]) + EW'(HEADER_BYTES);
                    cnt_next   = '0;
                    state_next = FS_SCAN;
                end
            end
            FS_SCAN: begin
                tok_next = head_tok;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SLOTS - 1)) begin
                    cnt_next = '0;
                    if (head_tok.kind) begin
                        tok_next.tlen = head_tok.need;
                        tok_next.toff = head_tok.off;
                    end
                    state_next = FS_PUSH;
                end
            end
            FS_PUSH: begin
                tok_next = head_tok;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SLOTS - 1)) state_next = FS_DONE;
            end
            FS_DONE: begin
                if (!mv_next) begin
                    lost = tok_reg.tlen != '0;
                    if (tok_reg.kind) st = lost ? ST_LOST : ST_FREED;
                    else st = tok_reg.hit ? ST_GRANTED : ST_NOFIT;
                    md_next = {tok_reg.kind || !tok_reg.hit ? FW'(0)
                                 : FW'(tok_reg.need) & {FW{1'b1}} ,
                               tok_reg.hit && !tok_reg.kind ? tok_reg.gstart[FW-1:0]
                                 : FW'(0), st};
                    if (tok_reg.kind) md_next[55:29] = tok_reg.need[FW-1:0];
                    mv_next    = 1'b1;
                    state_next = FS_IDLE;
                end
            end
            default: state_next = FS_IDLE;
        endcase
    end
endmodule

FILE: rtl/core/ffa_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_free_list_allocator.
module ffa_checker import ffa_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted while busy");
    a_nogs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_GRANTED |-> m_axis_tdata[28:2] == 27'd0)
        else $error("start set without grant");
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> ##2 !s_axis_tready)
        else $error("request finished too early");
endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (.*);
